### hdl/i2cm_pkg.sv
// Shared types and constants of the I2C master bit engine.
package i2cm_pkg;

  localparam int unsigned ReqTypeW = 3;
  localparam int unsigned ByteW    = 8;

  // Command queue between the decoder and the pin sequencer.
  localparam int unsigned CmdDepth = 2;
  localparam int unsigned PtrW     = $clog2(CmdDepth);
  localparam int unsigned CntW     = $clog2(CmdDepth + 1);

  // Pin step bookkeeping: up to 24 steps, three phases per written bit.
  localparam int unsigned StepW  = 5;
  localparam int unsigned PhaseW = 2;
  localparam int unsigned BitW   = 3;

  localparam logic [StepW-1:0]  StepFirst    = 5'd0;
  localparam logic [StepW-1:0]  StepSecond   = 5'd1;
  localparam logic [StepW-1:0]  StepThird    = 5'd2;
  localparam logic [StepW-1:0]  ReadLastStep = 5'd16;
  localparam logic [PhaseW-1:0] PhaseData    = 2'd0;
  localparam logic [PhaseW-1:0] PhaseHigh    = 2'd1;
  localparam logic [PhaseW-1:0] PhaseLow     = 2'd2;

  typedef enum logic [ReqTypeW-1:0] {
    CmdStart   = 3'd0,
    CmdStop    = 3'd1,
    CmdWrite   = 3'd2,
    CmdRead    = 3'd3,
    CmdSendAck = 3'd4,
    CmdReadAck = 3'd5
  } cmd_kind_e;

  // A decoded command: data holds the byte to send or the sampled byte,
  // ack_bit holds the level to send or the sampled acknowledge.
  typedef struct packed {
    cmd_kind_e        kind;
    logic [ByteW-1:0] data;
    logic             ack_bit;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_push_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_head_t;

endpackage

### hdl/i2cm_if.sv
// Valid/ready channel interfaces for commands and pin step results.
interface i2cm_req_if;
  import i2cm_pkg::*;

  logic                valid;
  logic                ready;
  logic [ReqTypeW-1:0] req_type;
  logic [ByteW-1:0]    write_data;
  logic                ack_to_send;
  logic [ByteW-1:0]    line_byte;
  logic                line_ack;

  modport source (
    output valid, req_type, write_data, ack_to_send, line_byte, line_ack,
    input  ready
  );
  modport sink (
    input  valid, req_type, write_data, ack_to_send, line_byte, line_ack,
    output ready
  );
endinterface

interface i2cm_rsp_if;
  import i2cm_pkg::*;

  logic             valid;
  logic             ready;
  logic             scl_level;
  logic             sda_level;
  logic [ByteW-1:0] received_byte;
  logic             received_ack;
  logic             last_step;

  modport source (
    output valid, scl_level, sda_level, received_byte, received_ack, last_step,
    input  ready
  );
  modport sink (
    input  valid, scl_level, sda_level, received_byte, received_ack, last_step,
    output ready
  );
endinterface

### hdl/i2cm_front.sv
// Command decoder: accepts request beats and packs known commands for the queue.
module i2cm_front (
  i2cm_req_if.sink              req_i,
  input  logic                  queue_full_i,
  output i2cm_pkg::cmd_push_t   push_o
);
  import i2cm_pkg::*;

  logic known;

  always_comb begin
    known = req_i.req_type inside {[CmdStart:CmdReadAck]};
  end

  assign req_i.ready = !queue_full_i;

  // Unknown codes are taken and dropped so they never reach the bus.
  always_comb begin
    push_o.valid       = req_i.valid && !queue_full_i && known;
    push_o.cmd.kind    = cmd_kind_e'(req_i.req_type);
    push_o.cmd.data    = req_i.write_data;
    push_o.cmd.ack_bit = req_i.ack_to_send;
    case (push_o.cmd.kind)
      CmdRead: begin
        push_o.cmd.data = req_i.line_byte;
      end
      CmdReadAck: begin
        push_o.cmd.ack_bit = req_i.line_ack;
      end
      default: begin
      end
    endcase
  end

endmodule

### hdl/i2cm_cmd_fifo.sv
// Two-entry command queue between the decoder and the pin sequencer.
module i2cm_cmd_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  i2cm_pkg::cmd_push_t   push_i,
  input  logic                  pop_i,
  output logic                  full_o,
  output i2cm_pkg::cmd_head_t   head_o
);
  import i2cm_pkg::*;

  cmd_t            mem_q [CmdDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_pop;

  assign full_o      = (cnt_q == CntW'(CmdDepth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = mem_q[rd_ptr_q];
  assign do_pop      = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i.valid) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(CmdDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(CmdDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i.valid && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !push_i.valid) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.cmd;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(CmdDepth))
    else $error("command queue count exceeds its depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i.valid)
    else $error("command pushed into a full queue");
`endif

endmodule

### hdl/i2cm_back.sv
// Pin sequencer: walks the queue head through its pin steps into the result register.
module i2cm_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  i2cm_pkg::cmd_head_t   head_i,
  output logic                  pop_o,
  i2cm_rsp_if.source            rsp_o
);
  import i2cm_pkg::*;

  logic              scl_q, scl_d;
  logic              sda_q, sda_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [BitW-1:0]   bit_q, bit_d;
  logic              out_valid_q, out_valid_d;
  logic              scl_out_q, sda_out_q, ack_out_q, last_out_q;
  logic [ByteW-1:0]  byte_out_q;

  logic              advance;
  logic              last;
  logic [ByteW-1:0]  rbyte;
  logic              rack;

  assign advance = head_i.valid && (!out_valid_q || rsp_o.ready);
  assign pop_o   = advance && last;

  // Pin levels of the current step; the pin not driven keeps its level.
  always_comb begin
    scl_d = scl_q;
    sda_d = sda_q;
    rbyte = '0;
    rack  = 1'b0;
    last  = 1'b0;
    case (head_i.cmd.kind)
      CmdStart: begin
        case (step_q)
          StepFirst:  sda_d = 1'b1;
          StepSecond: scl_d = 1'b1;
          StepThird:  sda_d = 1'b0;
          default: begin
            scl_d = 1'b0;
            last  = 1'b1;
          end
        endcase
      end
      CmdStop: begin
        case (step_q)
          StepFirst:  sda_d = 1'b0;
          StepSecond: scl_d = 1'b1;
          default: begin
            sda_d = 1'b1;
            last  = 1'b1;
          end
        endcase
      end
      CmdWrite: begin
        case (phase_q)
          PhaseData: sda_d = head_i.cmd.data[~bit_q];
          PhaseHigh: scl_d = 1'b1;
          default: begin
            scl_d = 1'b0;
            last  = &bit_q;
          end
        endcase
      end
      CmdRead: begin
        if (step_q == StepFirst) begin
          sda_d = 1'b1;
        end else if (step_q == ReadLastStep) begin
          scl_d = 1'b0;
          rbyte = head_i.cmd.data;
          last  = 1'b1;
        end else begin
          scl_d = step_q[0];
        end
      end
      CmdSendAck: begin
        case (step_q)
          StepFirst:  sda_d = head_i.cmd.ack_bit;
          StepSecond: scl_d = 1'b1;
          default: begin
            scl_d = 1'b0;
            last  = 1'b1;
          end
        endcase
      end
      CmdReadAck: begin
        case (step_q)
          StepFirst:  sda_d = 1'b1;
          StepSecond: scl_d = 1'b1;
          default: begin
            scl_d = 1'b0;
            rack  = head_i.cmd.ack_bit;
            last  = 1'b1;
          end
        endcase
      end
      default: begin
        last = 1'b1;
      end
    endcase
  end

  always_comb begin
    step_d  = step_q;
    phase_d = phase_q;
    bit_d   = bit_q;
    if (advance) begin
      if (last) begin
        step_d  = '0;
        phase_d = PhaseData;
        bit_d   = '0;
      end else begin
        step_d = step_q + 1'b1;
        if (phase_q == PhaseLow) begin
          phase_d = PhaseData;
          bit_d   = bit_q + 1'b1;
        end else begin
          phase_d = phase_q + 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      step_q      <= '0;
      phase_q     <= PhaseData;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        scl_q <= scl_d;
        sda_q <= sda_d;
      end
      step_q      <= step_d;
      phase_q     <= phase_d;
      bit_q       <= bit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      scl_out_q  <= scl_d;
      sda_out_q  <= sda_d;
      byte_out_q <= rbyte;
      ack_out_q  <= rack;
      last_out_q <= last;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.scl_level     = scl_out_q;
  assign rsp_o.sda_level     = sda_out_q;
  assign rsp_o.received_byte = byte_out_q;
  assign rsp_o.received_ack  = ack_out_q;
  assign rsp_o.last_step     = last_out_q;

`ifndef ASSERT_OFF
  a_rewind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && last) |=> (step_q == '0 && phase_q == PhaseData && bit_q == '0))
    else $error("step counters did not rewind after the final step");

  a_one_pin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |-> !((scl_d != scl_q) && (sda_d != sda_q)))
    else $error("both pins changed in a single step");

  a_idle_rest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_i.valid |-> (step_q == '0 && phase_q == PhaseData))
    else $error("step counters moved without a queued command");
`endif

endmodule

### hdl/i2c_master_bit_engine.sv
// Top level of the I2C master bit engine: decoder, command queue and pin sequencer.
//
//   Channel  Dir  Beat                     Payload
//   req_i    in   one bus primitive        req_type, write_data, ack_to_send,
//                                          line_byte, line_ack
//   rsp_o    out  one pin step             scl_level, sda_level, received_byte,
//                                          received_ack, last_step
//
// Each command produces one result beat per cycle while rsp_o is not stalled:
// start 4, stop 3, write byte 24, read byte 17, send ack 3, read ack 3 beats,
// set by the step counter of the sequencer. Steps of consecutive commands follow
// each other with no gap. Unknown codes are accepted and produce no beats.
// A two-entry queue lets commands be accepted while the sequencer is busy or
// while the result register is stalled; req_i.ready drops only when it is full.
// After reset both pins are held high (idle bus) and the queue is empty.
module i2c_master_bit_engine (
  input  logic         clk_i,
  input  logic         rst_ni,
  i2cm_req_if.sink     req_i,
  i2cm_rsp_if.source   rsp_o
);
  import i2cm_pkg::*;

  // Decoded commands flow front to back through the queue.
  cmd_push_t push;
  cmd_head_t head;
  logic      queue_full;
  logic      pop;

  i2cm_front u_front (
    .req_i        (req_i),
    .queue_full_i (queue_full),
    .push_o       (push)
  );

  i2cm_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .full_o (queue_full),
    .head_o (head)
  );

  // The sequencer pops the head on the cycle its final step is registered,
  // so the next command's first step follows directly.
  i2cm_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .rsp_o  (rsp_o)
  );

endmodule
